// ----- hw/rtl/lfa_pkg.sv -----
`default_nettype none

package lfa_pkg;

    localparam int CAPACITY = 256;

    // bitmap is held as rows of WORD_W marks
    localparam int WORD_W = 16;
    localparam int BIT_W  = 4;

    localparam int OP_W     = 2;
    localparam int NUM_W    = 8;
    localparam int LIMIT_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/lowest_free_id_allocator_core.sv -----
// Hands out the lowest free number below the limit in cfg_wdata (reset 256,
// clamped to the capacity), answers whether a number is free, and takes
// numbers back. Pulse start while busy is low; busy is then high for one
// cycle and the result appears on granted/available/status with done high
// for exactly one cycle once busy falls, after the state and the row read
// are registered at the accepting edge. done is never held off, so the
// receiver must take each result as it comes. A new item can be taken at the
// edge that ends the done cycle, not before: the block first reads a row of the
// taken bitmap from its synchronous memory, then searches or updates it and
// writes it back. Per-row valid and full flags sit in flip-flops, so the
// bitmap is all free straight out of reset with no clearing pass. Write
// cfg_wdata only while the block is idle.
`default_nettype none

module lowest_free_id_allocator_core #(
    parameter int CAPACITY = lfa_pkg::CAPACITY
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [lfa_pkg::OP_W-1:0]      operation,
    input  wire logic [lfa_pkg::NUM_W-1:0]     number,
    output logic                               busy,
    output logic                               done,
    output logic [lfa_pkg::NUM_W-1:0]          granted,
    output logic                               available,
    output logic [lfa_pkg::STATUS_W-1:0]       status,
    input  wire logic                          cfg_we,
    input  wire logic [lfa_pkg::LIMIT_W-1:0]   cfg_wdata
);

    localparam int STORE  = (CAPACITY < 256) ? CAPACITY : 256;
    localparam int WORD_W = lfa_pkg::WORD_W;
    localparam int BIT_W  = lfa_pkg::BIT_W;
    localparam int NWORDS = (STORE + WORD_W - 1) / WORD_W;
    localparam int WIDX_W = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int NDEPTH = 1 << WIDX_W;
    localparam int GNT_W  = WIDX_W + BIT_W;
    localparam int LIM_W  = lfa_pkg::LIMIT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                          state_reg;
    logic [LIM_W-1:0]                max_numbers_reg;
    logic [lfa_pkg::OP_W-1:0]        op_reg;
    logic [lfa_pkg::NUM_W-1:0]       num_reg;
    logic [WIDX_W-1:0]               row_reg;
    logic [NDEPTH-1:0]               row_valid_reg;
    logic [NDEPTH-1:0]               row_full_reg;
    logic                            done_reg;
    logic [lfa_pkg::NUM_W-1:0]       granted_reg;
    logic                            available_reg;
    logic [lfa_pkg::STATUS_W-1:0]    status_reg;

    logic [WORD_W-1:0]               mem [NDEPTH];
    logic [WORD_W-1:0]               rd_word_reg;
    logic                            rd_valid_reg;

    logic                            accept;
    logic [WIDX_W-1:0]               free_row;
    logic [WIDX_W-1:0]               rd_addr;
    logic [LIM_W-1:0]                lim;
    logic [WORD_W-1:0]               word;
    logic                            zero_found;
    logic [BIT_W-1:0]                zero_bit;
    logic [GNT_W-1:0]                gnt_idx;
    logic                            in_range;
    logic [BIT_W-1:0]                num_bit;
    logic                            wr_en;
    logic [WORD_W-1:0]               wr_word;
    logic [lfa_pkg::NUM_W-1:0]       granted_next;
    logic                            available_next;
    logic [lfa_pkg::STATUS_W-1:0]    status_next;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg == S_EXEC);
    assign done      = done_reg;
    assign granted   = granted_reg;
    assign available = available_reg;
    assign status    = status_reg;

    assign lim = (max_numbers_reg > LIM_W'(STORE)) ? LIM_W'(STORE) : max_numbers_reg;

    // first row not marked full; its lowest clear bit is the lowest free number
    always_comb
    begin
        free_row = '0;
        for (int i = NDEPTH - 1; i >= 0; i--)
        begin
            if (!row_full_reg[i])
                free_row = WIDX_W'(i);
        end
        rd_addr = (operation == lfa_pkg::OP_ALLOC) ? free_row : number[BIT_W +: WIDX_W];
    end

    always_comb
    begin
        word = rd_valid_reg ? rd_word_reg : '0;
        zero_found = 1'b0;
        zero_bit   = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (!word[b])
            begin
                zero_found = 1'b1;
                zero_bit   = BIT_W'(b);
            end
        end
        gnt_idx  = {row_reg, zero_bit};
        in_range = {1'b0, num_reg} < lim;
        num_bit  = num_reg[BIT_W-1:0];

        wr_en          = 1'b0;
        wr_word        = word;
        granted_next   = '0;
        available_next = 1'b0;
        status_next    = lfa_pkg::ST_OK;
        case (op_reg)
            lfa_pkg::OP_ALLOC:
            begin
                // a free bit at or above the limit means none below it
                if (zero_found && (LIM_W'(gnt_idx) < lim))
                begin
                    wr_en        = 1'b1;
                    wr_word      = word | (WORD_W'(1) << zero_bit);
                    granted_next = lfa_pkg::NUM_W'(gnt_idx);
                end
                else
                    status_next = lfa_pkg::ST_FULL;
            end
            lfa_pkg::OP_QUERY:
            begin
                available_next = in_range && !word[num_bit];
            end
            lfa_pkg::OP_RELEASE:
            begin
                if (!in_range)
                    status_next = lfa_pkg::ST_RANGE;
                else if (word[num_bit])
                begin
                    wr_en   = 1'b1;
                    wr_word = word & ~(WORD_W'(1) << num_bit);
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (busy && wr_en)
            mem[row_reg] <= wr_word;
        if (accept)
            rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            max_numbers_reg <= lfa_pkg::LIMIT_RESET;
            op_reg          <= lfa_pkg::OP_ALLOC;
            num_reg         <= '0;
            row_reg         <= '0;
            row_valid_reg   <= '0;
            row_full_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            done_reg        <= 1'b0;
            granted_reg     <= '0;
            available_reg   <= 1'b0;
            status_reg      <= lfa_pkg::ST_OK;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                max_numbers_reg <= cfg_wdata;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= operation;
                        num_reg      <= number;
                        row_reg      <= rd_addr;
                        rd_valid_reg <= row_valid_reg[rd_addr];
                        state_reg    <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (wr_en)
                    begin
                        row_valid_reg[row_reg] <= 1'b1;
                        row_full_reg[row_reg]  <= &wr_word;
                    end
                    done_reg      <= 1'b1;
                    granted_reg   <= granted_next;
                    available_reg <= available_next;
                    status_reg    <= status_next;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lfa_checker.sv -----
`default_nettype none

module lfa_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          done,
    input wire logic [lfa_pkg::NUM_W-1:0]     granted,
    input wire logic                          available,
    input wire logic [lfa_pkg::STATUS_W-1:0]  status
);

    // every accepted item yields its result, with no stall
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
    else $error("item accepted but no result two cycles later");

    // no result without a matching accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
    else $error("result without matching item");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && status == lfa_pkg::ST_FULL |-> granted == '0 && !available)
    else $error("full result carries a grant or availability");

    assert property (@(posedge clk) disable iff (!rst_n)
        done && available |-> status == lfa_pkg::ST_OK && granted == '0)
    else $error("free query with bad status or grant");

endmodule

bind lowest_free_id_allocator_core lfa_checker u_lfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .granted   (granted),
    .available (available),
    .status    (status)
);

`default_nettype wire
